>>> sv/nbr_etx_pkg.sv
// ---------------------------------------------------------------------------
// nbr_etx_pkg
// Shared types and codes of the neighbour ETX table.
// ---------------------------------------------------------------------------
package nbr_etx_pkg;

  localparam int ADDR_W   = 64;
  localparam int METRIC_W = 12;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 8;

  // request types
  localparam logic [1:0] REQ_SENT  = 2'd0;
  localparam logic [1:0] REQ_RECV  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // transmit status
  localparam logic [1:0] TX_OK    = 2'd0;
  localparam logic [1:0] TX_NOACK = 2'd1;

  // result outcomes
  localparam logic [2:0] OUT_IGNORED = 3'd0;
  localparam logic [2:0] OUT_SAME    = 3'd1;
  localparam logic [2:0] OUT_CHANGED = 3'd2;
  localparam logic [2:0] OUT_ABSENT  = 3'd3;
  localparam logic [2:0] OUT_QUERY   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_WEIGHT  = 2'd0;
  localparam logic [1:0] CFG_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_PENALTY = 2'd2;

  localparam logic [6:0] WEIGHT_RST  = 7'd90;
  localparam logic [7:0] LIMIT_RST   = 8'd15;
  localparam logic [7:0] PENALTY_RST = 8'd15;

  localparam logic [6:0] PCT_FULL = 7'd100;

  // floor(x / 100) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 2^19
  localparam int          SUM_W     = 19;
  localparam int          RECIP_W   = 20;
  localparam logic [19:0] DIV_RECIP = 20'd671089;
  localparam int          DIV_SHIFT = 26;

  typedef enum logic [2:0] {
    K_IGNORE     = 3'd0,
    K_RECV       = 3'd1,
    K_SENT_OK    = 3'd2,
    K_SENT_NOACK = 3'd3,
    K_QUERY      = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   addr;
    logic [METRIC_W-1:0] sample;
    logic [TIME_W-1:0]   now;
  } q_entry_t;

  typedef struct packed {
    logic [6:0] weight;
    logic [7:0] limit;
    logic [7:0] penalty;
  } cfg_t;

endpackage

>>> sv/neighbor_etx_ewma_table.sv
// ---------------------------------------------------------------------------
// neighbor_etx_ewma_table
// Neighbour table with a fixed-point ETX moving average per link.
// ---------------------------------------------------------------------------
// Items pass one at a time through the table engine's three steps
//   (address match and metric read, products, divide by 100 and write-back);
//   the engine takes no new item until the last is written back.
// The two-entry queue takes items while the engine works or the result stalls.
// Reset: valid bits clear at once (no clearing pass); config returns to
//   weight 90, limit 15, penalty 15.
module neighbor_etx_ewma_table import nbr_etx_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int FIX_SCALE     = 16
) (
  input  logic                clk,
  input  logic                rst,
  // item input
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [ADDR_W-1:0]   neighbor_address,
  input  logic [1:0]          tx_status,
  input  logic [7:0]          tx_count,
  input  logic [TIME_W-1:0]   now_seconds,
  // result output
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          outcome,
  output logic [ADDR_W-1:0]   result_address,
  output logic [METRIC_W-1:0] link_metric,
  output logic                metric_changed,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  cfg_t     cfg;
  q_entry_t front_entry;
  q_entry_t q_head;
  logic     q_full;
  logic     q_not_empty;
  logic     q_pop;
  logic     push;

  // Configuration registers; writes to unlisted indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight  <= WEIGHT_RST;
      cfg.limit   <= LIMIT_RST;
      cfg.penalty <= PENALTY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WEIGHT:  cfg.weight  <= cfg_data[6:0];
        CFG_LIMIT:   cfg.limit   <= cfg_data[7:0];
        CFG_PENALTY: cfg.penalty <= cfg_data[7:0];
        default:     ;
      endcase
    end
  end

  // Front: classify and scale the sample as the item arrives.
  nbr_etx_front #(
    .FIX_SCALE (FIX_SCALE)
  ) u_front (
    .req_type         (req_type),
    .neighbor_address (neighbor_address),
    .tx_status        (tx_status),
    .tx_count         (tx_count),
    .now_seconds      (now_seconds),
    .noack_penalty    (cfg.penalty),
    .entry            (front_entry)
  );

  // Input stalls only when the queue is full.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  nbr_etx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Back: table lookup, average and result register.
  nbr_etx_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FIX_SCALE     (FIX_SCALE)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_not_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .cfg            (cfg),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .outcome        (outcome),
    .result_address (result_address),
    .link_metric    (link_metric),
    .metric_changed (metric_changed)
  );

endmodule

>>> sv/nbr_etx_front.sv
// ---------------------------------------------------------------------------
// nbr_etx_front
// Classifies an incoming item and forms its scaled ETX sample.
// ---------------------------------------------------------------------------
module nbr_etx_front import nbr_etx_pkg::*; #(
  parameter int FIX_SCALE = 16
) (
  input  logic [1:0]        req_type,
  input  logic [ADDR_W-1:0] neighbor_address,
  input  logic [1:0]        tx_status,
  input  logic [7:0]        tx_count,
  input  logic [TIME_W-1:0] now_seconds,
  input  logic [7:0]        noack_penalty,
  output q_entry_t          entry
);

  logic        null_addr;
  kind_t       kind;
  logic [7:0]  count;
  logic [12:0] scaled;

  assign null_addr = (neighbor_address == '0);

  always_comb begin
    unique case (req_type)
      REQ_QUERY: kind = K_QUERY;
      REQ_RECV:  kind = null_addr ? K_IGNORE : K_RECV;
      REQ_SENT: begin
        if (null_addr)                  kind = K_IGNORE;
        else if (tx_status == TX_OK)    kind = K_SENT_OK;
        else if (tx_status == TX_NOACK) kind = K_SENT_NOACK;
        else                            kind = K_IGNORE;
      end
      default:   kind = K_IGNORE;
    endcase
  end

  // no-ack charges the penalty count
  assign count  = (kind == K_SENT_NOACK) ? noack_penalty : tx_count;
  assign scaled = 13'(count) * 13'(FIX_SCALE);

  assign entry.kind   = kind;
  assign entry.addr   = neighbor_address;
  assign entry.sample = scaled[METRIC_W-1:0];
  assign entry.now    = now_seconds;

endmodule

>>> sv/nbr_etx_queue.sv
// ---------------------------------------------------------------------------
// nbr_etx_queue
// Two-entry queue between the classifier and the table engine.
// ---------------------------------------------------------------------------
module nbr_etx_queue import nbr_etx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output q_entry_t head
);

  q_entry_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

>>> sv/nbr_etx_engine.sv
// ---------------------------------------------------------------------------
// nbr_etx_engine
// Neighbour table: address match, metric average and result register.
// ---------------------------------------------------------------------------
module nbr_etx_engine import nbr_etx_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int FIX_SCALE     = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  q_entry_t            q_head,
  output logic                q_pop,
  input  cfg_t                cfg,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          outcome,
  output logic [ADDR_W-1:0]   result_address,
  output logic [METRIC_W-1:0] link_metric,
  output logic                metric_changed
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [2:0] {
    S_MATCH  = 3'b001,
    S_CALC   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state;

  logic [TABLE_ENTRIES-1:0] valid;
  logic [ADDR_W-1:0]        addr_tab   [TABLE_ENTRIES];
  logic [METRIC_W-1:0]      metric_mem [TABLE_ENTRIES];
  logic [TIME_W-1:0]        ts_mem     [TABLE_ENTRIES];
  logic [METRIC_W-1:0]      metric_rd;

  // match
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             adding;
  logic [IDX_W-1:0] sel_idx;

  // held item
  kind_t               p_kind;
  logic [ADDR_W-1:0]   p_addr;
  logic [METRIC_W-1:0] p_sample;
  logic [TIME_W-1:0]   p_now;
  logic [IDX_W-1:0]    p_idx;
  logic                p_ok;
  logic                p_new;

  // average
  logic [6:0]          weight;
  logic [6:0]          weight_inv;
  logic [METRIC_W-1:0] old_cur;
  logic [METRIC_W-1:0] old_r;
  logic                first_r;
  logic [SUM_W-1:0]    sum_r;
  logic [12:0]         limit_prod;
  logic [METRIC_W-1:0] limit_r;
  logic [SUM_W+RECIP_W-1:0] quot_full;
  logic [METRIC_W-1:0] avg_metric;
  logic                changed;

  // commit
  logic                out_free;
  logic                commit;
  logic [2:0]          res_outcome;
  logic [METRIC_W-1:0] res_metric;
  logic                res_changed;
  logic                wr_en;
  logic [METRIC_W-1:0] wr_metric;
  logic [TIME_W-1:0]   wr_ts;

  // lowest free slot and matching slot, one comparator per entry
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && (addr_tab[i] == q_head.addr)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign adding  = ((q_head.kind == K_RECV) || (q_head.kind == K_SENT_OK)) &&
                   !hit && free_found;
  assign sel_idx = hit ? hit_idx : free_idx;
  assign q_pop   = (state == S_MATCH) && q_valid;

  assign weight     = (cfg.weight > PCT_FULL) ? PCT_FULL : cfg.weight;
  assign weight_inv = PCT_FULL - weight;
  assign old_cur    = p_new ? '0 : metric_rd;
  assign limit_prod = 13'(cfg.limit) * 13'(FIX_SCALE);

  assign quot_full  = (SUM_W+RECIP_W)'(sum_r) * (SUM_W+RECIP_W)'(DIV_RECIP);
  assign avg_metric = first_r ? p_sample : quot_full[DIV_SHIFT +: METRIC_W];
  assign changed    = first_r || (avg_metric != old_r);

  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == S_COMMIT) && out_free;

  always_comb begin
    res_outcome = OUT_IGNORED;
    res_metric  = '0;
    res_changed = 1'b0;
    wr_en       = 1'b0;
    wr_metric   = '0;
    wr_ts       = '0;
    case (p_kind)
      K_QUERY: begin
        res_outcome = OUT_QUERY;
        res_metric  = p_ok ? old_r : limit_r;
      end
      K_RECV: begin
        if (p_ok) begin
          res_outcome = OUT_SAME;
          res_metric  = old_r;
          wr_en       = p_new;
        end else begin
          res_outcome = OUT_ABSENT;
        end
      end
      K_SENT_OK, K_SENT_NOACK: begin
        if (p_ok) begin
          res_outcome = changed ? OUT_CHANGED : OUT_SAME;
          res_metric  = avg_metric;
          res_changed = changed;
          wr_en       = 1'b1;
          wr_metric   = avg_metric;
          wr_ts       = p_now;
        end else begin
          res_outcome = OUT_ABSENT;
        end
      end
      default: res_outcome = OUT_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_MATCH;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !commit) out_valid <= 1'b0;
      unique case (state)
        S_MATCH: begin
          if (q_valid) begin
            if (adding) valid[sel_idx] <= 1'b1;
            state <= S_CALC;
          end
        end
        S_CALC:   state <= S_COMMIT;
        S_COMMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_MATCH;
          end
        end
        default:  state <= S_MATCH;
      endcase
    end
  end

  // payload and table storage
  always_ff @(posedge clk) begin
    metric_rd <= metric_mem[sel_idx];
    if (q_pop) begin
      p_kind   <= q_head.kind;
      p_addr   <= q_head.addr;
      p_sample <= q_head.sample;
      p_now    <= q_head.now;
      p_idx    <= sel_idx;
      p_ok     <= hit || adding;
      p_new    <= adding;
      if (adding) addr_tab[sel_idx] <= q_head.addr;
    end
    if (state == S_CALC) begin
      old_r   <= old_cur;
      first_r <= (old_cur == '0);
      sum_r   <= SUM_W'(old_cur) * SUM_W'(weight) + SUM_W'(p_sample) * SUM_W'(weight_inv);
      limit_r <= limit_prod[METRIC_W-1:0];
    end
    if (commit) begin
      outcome        <= res_outcome;
      result_address <= p_addr;
      link_metric    <= res_metric;
      metric_changed <= res_changed;
      if (wr_en) begin
        metric_mem[p_idx] <= wr_metric;
        ts_mem[p_idx]     <= wr_ts;
      end
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for neighbor_etx_ewma_table: a directed table of
// items, then constrained-by-hand random traffic over several register
// settings, every result checked against its row or an in-bench model of the table.
// ---------------------------------------------------------------------------
module tb_top import nbr_etx_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = 16;
  localparam int FIX_SCALE     = 16;

  // codes the package leaves unnamed
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] TX_FAIL    = 2'd2;
  localparam logic [1:0] TX_RSVD    = 2'd3;

  localparam int RST_CYCLES     = 9;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 8;
  localparam int POOL_SIZE      = 20;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 114;

  localparam logic [ADDR_W-1:0] ADDR_A   = 64'h0123_4567_89AB_CDEF;
  localparam logic [ADDR_W-1:0] ADDR_B   = 64'h8000_0000_0000_0000;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
  localparam logic [ADDR_W-1:0] ADDR_NUL = '0;

  typedef struct packed {
    logic [1:0]        req;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
    logic [7:0]        count;
    logic [TIME_W-1:0] now;
  } nbr_req_t;

  typedef struct packed {
    logic [2:0]          outcome;
    logic [ADDR_W-1:0]   addr;
    logic [METRIC_W-1:0] metric;
    logic                changed;
  } nbr_res_t;

  typedef struct packed {
    nbr_req_t item;
    logic     typed;   // expected result written into the row
    nbr_res_t res;
  } dir_row_t;

  // -------------------------------------------------------------------------
  // DUT signals; every DUT input known from time zero
  // -------------------------------------------------------------------------
  logic                clk              = 1'b0;
  logic                rst              = 1'b1;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [1:0]          req_type         = '0;
  logic [ADDR_W-1:0]   neighbor_address = '0;
  logic [1:0]          tx_status        = '0;
  logic [7:0]          tx_count         = '0;
  logic [TIME_W-1:0]   now_seconds      = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [2:0]          outcome;
  logic [ADDR_W-1:0]   result_address;
  logic [METRIC_W-1:0] link_metric;
  logic                metric_changed;
  logic                cfg_we           = 1'b0;
  logic [1:0]          cfg_index        = '0;
  logic [CFG_W-1:0]    cfg_data         = '0;

  neighbor_etx_ewma_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .FIX_SCALE    (FIX_SCALE)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .neighbor_address(neighbor_address),
    .tx_status       (tx_status),
    .tx_count        (tx_count),
    .now_seconds     (now_seconds),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .outcome         (outcome),
    .result_address  (result_address),
    .link_metric     (link_metric),
    .metric_changed  (metric_changed),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Bench state
  // -------------------------------------------------------------------------
  int unsigned in_idle_pct  = 0;   // chance per cycle that the sender holds off
  int unsigned out_idle_pct = 0;   // chance per cycle that the receiver stalls
  int unsigned err_count    = 0;

  nbr_res_t          pending_results[$];   // expected results, oldest first
  dir_row_t          directed_rows[$];
  logic [ADDR_W-1:0] addr_pool[POOL_SIZE];

  // shadow of the registers, tracking what has been written
  logic [6:0] cfg_weight  = WEIGHT_RST;
  logic [7:0] cfg_limit   = LIMIT_RST;
  logic [7:0] cfg_penalty = PENALTY_RST;

  // shadow of the neighbour table
  logic                nbr_valid [TABLE_ENTRIES];
  logic [ADDR_W-1:0]   nbr_addr  [TABLE_ENTRIES];
  logic [METRIC_W-1:0] nbr_metric[TABLE_ENTRIES];
  logic [TIME_W-1:0]   nbr_stamp [TABLE_ENTRIES];

  // -------------------------------------------------------------------------
  // Table model
  // -------------------------------------------------------------------------
  function automatic int lookup_nbr(input logic [ADDR_W-1:0] a);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (nbr_valid[i] && nbr_addr[i] == a) return i;
    end
    return -1;
  endfunction

  // existing slot, else lowest free slot (cleared), else -1 when full
  function automatic int claim_nbr(input logic [ADDR_W-1:0] a);
    int slot;
    slot = lookup_nbr(a);
    if (slot >= 0) return slot;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!nbr_valid[i]) begin
        nbr_valid[i]  = 1'b1;
        nbr_addr[i]   = a;
        nbr_metric[i] = '0;
        nbr_stamp[i]  = '0;
        return i;
      end
    end
    return -1;
  endfunction

  // applies one item to the shadow table and returns the result it gives
  function automatic nbr_res_t etx_table_step(input nbr_req_t it);
    nbr_res_t            r;
    int                  slot;
    logic [7:0]          cnt;
    logic [METRIC_W-1:0] sample;
    logic [METRIC_W-1:0] prev;
    logic [METRIC_W-1:0] nm;
    int unsigned         w;
    int unsigned         acc;
    r.outcome = OUT_IGNORED;
    r.addr    = it.addr;
    r.metric  = '0;
    r.changed = 1'b0;
    if (it.req == REQ_QUERY) begin
      slot      = lookup_nbr(it.addr);
      r.outcome = OUT_QUERY;
      r.metric  = (slot >= 0) ? nbr_metric[slot]
                              : METRIC_W'(int'(cfg_limit) * FIX_SCALE);
      return r;
    end
    if ((it.req != REQ_SENT && it.req != REQ_RECV) || it.addr == ADDR_NUL) return r;
    if (it.req == REQ_RECV) begin
      slot = claim_nbr(it.addr);
      if (slot >= 0) begin
        r.outcome = OUT_SAME;
        r.metric  = nbr_metric[slot];
      end else begin
        r.outcome = OUT_ABSENT;
      end
      return r;
    end
    // sent report
    cnt = it.count;
    if (it.status == TX_OK) begin
      slot = claim_nbr(it.addr);
    end else if (it.status == TX_NOACK) begin
      cnt  = cfg_penalty;
      slot = lookup_nbr(it.addr);
    end else begin
      return r;
    end
    if (slot < 0) begin
      r.outcome = OUT_ABSENT;
      return r;
    end
    sample = METRIC_W'(int'(cnt) * FIX_SCALE);
    prev   = nbr_metric[slot];
    w      = (cfg_weight > PCT_FULL) ? int'(PCT_FULL) : int'(cfg_weight);
    if (prev == '0) begin
      nm        = sample;   // first sample, or metric still zero
      r.changed = 1'b1;
    end else begin
      acc       = int'(prev) * w + int'(sample) * (int'(PCT_FULL) - w);
      nm        = METRIC_W'(acc / int'(PCT_FULL));
      r.changed = (nm != prev);
    end
    nbr_metric[slot] = nm;
    nbr_stamp[slot]  = it.now;
    r.outcome = r.changed ? OUT_CHANGED : OUT_SAME;
    r.metric  = nm;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic dir_row_t mk_row(input logic [1:0] rq, input logic [ADDR_W-1:0] a,
                                      input logic [1:0] st, input logic [7:0] cn,
                                      input logic [TIME_W-1:0] tm, input logic typed,
                                      input logic [2:0] oc, input logic [METRIC_W-1:0] me,
                                      input logic ch);
    dir_row_t d;
    d.item.req    = rq;
    d.item.addr   = a;
    d.item.status = st;
    d.item.count  = cn;
    d.item.now    = tm;
    d.typed       = typed;
    d.res.outcome = oc;
    d.res.addr    = a;
    d.res.metric  = me;
    d.res.changed = ch;
    return d;
  endfunction

  // mostly well-formed sent reports on a small set of neighbours; some noise
  function automatic nbr_req_t random_item();
    nbr_req_t    it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 68)      it.req = REQ_SENT;
    else if (pick < 84) it.req = REQ_RECV;
    else if (pick < 97) it.req = REQ_QUERY;
    else                it.req = REQ_UNUSED;
    pick = $urandom_range(99);
    if (pick < 85)      it.addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
    else if (pick < 90) it.addr = ADDR_NUL;
    else                it.addr = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 62)      it.status = TX_OK;
    else if (pick < 86) it.status = TX_NOACK;
    else if (pick < 93) it.status = TX_FAIL;
    else                it.status = TX_RSVD;
    pick = $urandom_range(99);
    if (pick < 12)      it.count = 8'($urandom_range(255));
    else if (pick < 17) it.count = '0;   // zero sample pulls the metric toward zero
    else                it.count = 8'($urandom_range(6, 1));
    it.now = $urandom;
    return it;
  endfunction

  // present one item, hold it until taken, then log what it should give
  task automatic send_item(input nbr_req_t it, input logic typed, input nbr_res_t typed_res);
    nbr_res_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    req_type         <= it.req;
    neighbor_address <= it.addr;
    tx_status        <= it.status;
    tx_count         <= it.count;
    now_seconds      <= it.now;
    do @(posedge clk); while (in_stall);
    predicted = etx_table_step(it);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // back-to-back register writes; only called with the block idle
  task automatic load_settings(input logic [6:0] w, input logic [7:0] lim,
                               input logic [7:0] pen);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WEIGHT;
    cfg_data  <= CFG_W'(w);
    @(negedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_data  <= lim;
    @(negedge clk);
    cfg_index <= CFG_PENALTY;
    cfg_data  <= pen;
    @(negedge clk);
    cfg_we      <= 1'b0;
    cfg_weight  = w;
    cfg_limit   = lim;
    cfg_penalty = pen;
  endtask

  task automatic flag_mismatch(input string msg);
    err_count++;
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stall, and checking of every accepted result
  // -------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      out_stall <= !rst && ($urandom_range(99) < out_idle_pct);
    end
  end

  initial begin : result_check
    nbr_res_t e;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected, addr %h", result_address));
        end else begin
          e = pending_results.pop_front();
          if (outcome !== e.outcome)
            flag_mismatch($sformatf("outcome %0d, expected %0d (addr %h)",
                                    outcome, e.outcome, e.addr));
          if (result_address !== e.addr)
            flag_mismatch($sformatf("result_address %h, expected %h",
                                    result_address, e.addr));
          if (link_metric !== e.metric)
            flag_mismatch($sformatf("link_metric %0d, expected %0d (addr %h)",
                                    link_metric, e.metric, e.addr));
          if (metric_changed !== e.changed)
            flag_mismatch($sformatf("metric_changed %b, expected %b (addr %h)",
                                    metric_changed, e.changed, e.addr));
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: too long without any handshake on either channel ends the run
  // -------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : main_seq
    nbr_res_t    no_res;
    logic [6:0]  ph_w[PHASES];
    logic [7:0]  ph_lim[PHASES];
    logic [7:0]  ph_pen[PHASES];
    no_res = '0;

    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      nbr_valid[i]  = 1'b0;
      nbr_addr[i]   = '0;
      nbr_metric[i] = '0;
      nbr_stamp[i]  = '0;
    end
    // more neighbours than slots, so the table fills during the random part
    for (int i = 0; i < POOL_SIZE; i++) begin
      addr_pool[i] = {$urandom, $urandom};
      if (addr_pool[i] == ADDR_NUL) addr_pool[i] = 64'd1;
    end

    // settings per random phase: both extremes, weight above 100, a midpoint, reset values, a draw
    ph_w[0] = 7'd0;    ph_lim[0] = 8'd1;   ph_pen[0] = 8'd1;
    ph_w[1] = 7'd100;  ph_lim[1] = 8'd255; ph_pen[1] = 8'd255;
    ph_w[2] = 7'd127;  ph_lim[2] = 8'd200; ph_pen[2] = 8'd7;
    ph_w[3] = 7'd50;   ph_lim[3] = 8'd128; ph_pen[3] = 8'd255;
    ph_w[4] = WEIGHT_RST; ph_lim[4] = LIMIT_RST; ph_pen[4] = PENALTY_RST;
    ph_w[5] = 7'($urandom_range(100));
    ph_lim[5] = 8'($urandom_range(255, 1));
    ph_pen[5] = 8'($urandom_range(255, 1));

    // Directed rows, run with reset settings (limit 15 -> 240).
    // Fields: req, addr, status, count, now, typed, outcome, metric, changed.
    directed_rows.push_back(mk_row(REQ_QUERY, ADDR_NUL, TX_OK, 8'd0, 32'd0,
                                   1'b1, OUT_QUERY, 12'd240, 1'b0));     // null queried
    directed_rows.push_back(mk_row(REQ_SENT, ADDR_NUL, TX_OK, 8'd5, 32'd1,
                                   1'b1, OUT_IGNORED, 12'd0, 1'b0));     // null sent
    directed_rows.push_back(mk_row(REQ_RECV, ADDR_NUL, TX_OK, 8'd0, 32'd2,
                                   1'b1, OUT_IGNORED, 12'd0, 1'b0));     // null received
    directed_rows.push_back(mk_row(REQ_UNUSED, ADDR_MAX, TX_RSVD, 8'd255, '1,
                                   1'b1, OUT_IGNORED, 12'd0, 1'b0));     // unused request
    directed_rows.push_back(mk_row(REQ_SENT, ADDR_A, TX_NOACK, 8'd3, 32'd10,
                                   1'b1, OUT_ABSENT, 12'd0, 1'b0));      // no-ack, unknown
    directed_rows.push_back(mk_row(REQ_QUERY, ADDR_A, TX_OK, 8'd0, 32'd11,
                                   1'b1, OUT_QUERY, 12'd240, 1'b0));     // absent query
    directed_rows.push_back(mk_row(REQ_RECV, ADDR_A, TX_OK, 8'd0, 32'd12,
                                   1'b1, OUT_SAME, 12'd0, 1'b0));        // add on receive
    directed_rows.push_back(mk_row(REQ_SENT, ADDR_A, TX_OK, 8'd0, 32'd13,
                                   1'b1, OUT_CHANGED, 12'd0, 1'b0 | 1'b1)); // zero sample
    directed_rows.push_back(mk_row(REQ_SENT, ADDR_A, TX_OK, 8'd255, 32'd14,
                                   1'b1, OUT_CHANGED, 12'd4080, 1'b1));  // set outright again
    directed_rows.push_back(mk_row(REQ_SENT, ADDR_A, TX_OK, 8'd1, 32'd15,
                                   1'b0, '0, '0, 1'b0));                 // average down
    directed_rows.push_back(mk_row(REQ_SENT, ADDR_A, TX_NOACK, 8'd200, 32'd16,
                                   1'b0, '0, '0, 1'b0));                 // penalty sample
    directed_rows.push_back(mk_row(REQ_SENT, ADDR_A, TX_FAIL, 8'd2, 32'd17,
                                   1'b1, OUT_IGNORED, 12'd0, 1'b0));     // collision
    directed_rows.push_back(mk_row(REQ_SENT, ADDR_A, TX_RSVD, 8'd2, 32'd18,
                                   1'b1, OUT_IGNORED, 12'd0, 1'b0));     // reserved status
    directed_rows.push_back(mk_row(REQ_QUERY, ADDR_A, TX_RSVD, 8'd0, 32'd19,
                                   1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(REQ_SENT, ADDR_MAX, TX_OK, 8'd255, '1,
                                   1'b1, OUT_CHANGED, 12'd4080, 1'b1));  // all-ones address
    directed_rows.push_back(mk_row(REQ_RECV, ADDR_MAX, TX_OK, 8'd0, 32'd20,
                                   1'b1, OUT_SAME, 12'd4080, 1'b0));
    directed_rows.push_back(mk_row(REQ_SENT, ADDR_B, TX_OK, 8'd3, 32'd0,
                                   1'b1, OUT_CHANGED, 12'd48, 1'b1));
    directed_rows.push_back(mk_row(REQ_SENT, ADDR_B, TX_OK, 8'd3, 32'd21,
                                   1'b0, '0, '0, 1'b0));                 // steady, unchanged
    directed_rows.push_back(mk_row(REQ_RECV, ADDR_B, TX_OK, 8'd0, 32'd22,
                                   1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(REQ_QUERY, ADDR_B, TX_OK, 8'd0, 32'd23,
                                   1'b0, '0, '0, 1'b0));

    // single reset, released on a falling edge
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles 24 %, receiver 70 %
    in_idle_pct  = 24;
    out_idle_pct = 70;
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      load_settings(ph_w[p], ph_lim[p], ph_pen[p]);
      // first two phases as above, then swapped, then no idling at all
      if (p < 2) begin
        in_idle_pct  = 24;
        out_idle_pct = 70;
      end else if (p < 4) begin
        in_idle_pct  = 70;
        out_idle_pct = 24;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender holds off once mid-phase until the pipe is empty
        if (p == 1 && n == PHASE_ITEMS / 2) drain();
        send_item(random_item(), 1'b0, no_res);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> neighbor_etx_ewma_table.f
sv/nbr_etx_pkg.sv
sv/nbr_etx_front.sv
sv/nbr_etx_queue.sv
sv/nbr_etx_engine.sv
sv/neighbor_etx_ewma_table.sv
tb/sv/tb_top.sv
